/* rtl/core/cpra_pkg.sv */
// Shared types and constants for the contiguous page run allocator.
// Holds the map geometry, register indexes and the control/status structs.
// Depends on nothing; used by every module of the block except cpra_checker.
package cpra_pkg;

	localparam int unsigned MAP_AW = 8;
	localparam logic [8:0] MAX_PAGES = 9'd256;

	localparam logic [1:0] REG_USABLE_PAGES = 2'd0;
	localparam logic [1:0] REG_BASE_PAGE    = 2'd1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic fill;
		logic clear;
		logic emit;
	} cpra_cmd_t;

	typedef struct packed {
		logic bad_count;
		logic scan_hit;
		logic scan_last;
		logic fill_last;
		logic walk_cont;
	} cpra_stat_t;

endpackage

/* rtl/core/contiguous_page_run_allocator_unit.sv */
// Allocate: accept, scan up to usable_pages (at most 256) map entries, one per cycle,
// then fill the run one page per cycle, then emit once the output register is free.
// Free: accept, then a map read (ST_FRD) and a check (ST_FCHK) per page until the walk stops.
// One item is in work at a time; the result register lets the next item enter.
// arst_n clears every page to free and sets usable_pages to 256, base_page to 0.
module contiguous_page_run_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // page_count[8:0], free_page[28:9], zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // page_number[19:0], pages_freed[28:20], zero pad
	output logic        m_tuser,   // ok
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	cpra_pkg::cpra_cmd_t  cmd;
	cpra_pkg::cpra_stat_t stat;
	logic [19:0]          res_page_number;
	logic [8:0]           res_pages_freed;

	cpra_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_cmd          (s_tuser),
		.in_page_count   (s_tdata[8:0]),
		.in_free_page    (s_tdata[28:9]),
		.cmd             (cmd),
		.stat            (stat),
		.res_ok          (m_tuser),
		.res_page_number (res_page_number),
		.res_pages_freed (res_pages_freed)
	);

	cpra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_cmd   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign m_tdata = {3'b000, res_pages_freed, res_page_number};

endmodule

/* rtl/core/cpra_datapath.sv */
// Datapath of the page run allocator: page map memory, occupancy bits,
// scan and walk counters, configuration registers and the result register.
// Depends on cpra_pkg; driven by cpra_ctrl through command and status structs.
module cpra_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [19:0]          cfg_data,
	input  logic                 in_cmd,
	input  logic [8:0]           in_page_count,
	input  logic [19:0]          in_free_page,
	input  cpra_pkg::cpra_cmd_t  cmd,
	output cpra_pkg::cpra_stat_t stat,
	output logic                 res_ok,
	output logic [19:0]          res_page_number,
	output logic [8:0]           res_pages_freed
);

	logic [8:0]                        page_map_q [cpra_pkg::MAX_PAGES];
	logic [cpra_pkg::MAX_PAGES-1:0]    occ_q;
	logic [8:0]                        rd_q;
	logic [8:0]                        usable_q;
	logic [19:0]                       base_q;
	logic                              op_q;
	logic [8:0]                        count_q;
	logic [cpra_pkg::MAP_AW-1:0]       idx_q;
	logic [8:0]                        run_q;
	logic                              found_q;
	logic [cpra_pkg::MAP_AW-1:0]       first_q;
	logic [cpra_pkg::MAP_AW-1:0]       fill_q;
	logic [8:0]                        pos_q;
	logic                              walk_first_q;
	logic [9:0]                        expect_q;
	logic [8:0]                        cleared_q;
	logic [8:0]                        size;
	logic [19:0]                       offset;
	logic [8:0]                        cur_val;
	logic [cpra_pkg::MAP_AW-1:0]       fill_addr;

	assign size = (usable_q > cpra_pkg::MAX_PAGES) ? cpra_pkg::MAX_PAGES : usable_q;
	assign offset = in_free_page - base_q;
	assign fill_addr = first_q + fill_q;
	assign cur_val = occ_q[pos_q[cpra_pkg::MAP_AW-1:0]] ? rd_q : 9'd0;

	assign stat.bad_count = (count_q == 9'd0) || (count_q > size);
	assign stat.scan_hit = !occ_q[idx_q] && (({1'b0, run_q} + 10'd1) == {1'b0, count_q});
	assign stat.scan_last = (({1'b0, idx_q} + 9'd1) == size);
	assign stat.fill_last = (({1'b0, fill_q} + 9'd1) == count_q);
	assign stat.walk_cont = (pos_q < size) && (cur_val != 9'd0) &&
		(walk_first_q || ({1'b0, cur_val} == expect_q));

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			page_map_q[fill_addr] <= {1'b0, fill_q} + 9'd1;
		end
		rd_q <= page_map_q[pos_q[cpra_pkg::MAP_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			usable_q <= 9'd256;
			base_q <= 20'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cpra_pkg::REG_USABLE_PAGES: usable_q <= cfg_data[8:0];
					cpra_pkg::REG_BASE_PAGE:    base_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fill) begin
				occ_q[fill_addr] <= 1'b1;
			end
			if (cmd.clear) begin
				occ_q[pos_q[cpra_pkg::MAP_AW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.scan && stat.scan_hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_cmd;
			count_q <= in_page_count;
			idx_q <= '0;
			run_q <= 9'd0;
			fill_q <= '0;
			pos_q <= (offset[19:8] != 12'd0) ? 9'd256 : {1'b0, offset[7:0]};
			walk_first_q <= 1'b1;
			expect_q <= 10'd0;
			cleared_q <= 9'd0;
		end else begin
			if (cmd.scan) begin
				run_q <= occ_q[idx_q] ? 9'd0 : run_q + 9'd1;
				idx_q <= idx_q + 8'd1;
				if (stat.scan_hit) begin
					first_q <= idx_q + 8'd1 - count_q[cpra_pkg::MAP_AW-1:0];
				end
			end
			if (cmd.fill) begin
				fill_q <= fill_q + 8'd1;
			end
			if (cmd.clear) begin
				pos_q <= pos_q + 9'd1;
				expect_q <= {1'b0, cur_val} + 10'd1;
				cleared_q <= cleared_q + 9'd1;
				walk_first_q <= 1'b0;
			end
		end
		if (cmd.emit) begin
			if (op_q == cpra_pkg::CMD_FREE) begin
				res_ok <= (cleared_q != 9'd0);
				res_page_number <= 20'd0;
				res_pages_freed <= cleared_q;
			end else begin
				res_ok <= found_q;
				res_page_number <= found_q ? base_q + {12'd0, first_q} : 20'd0;
				res_pages_freed <= 9'd0;
			end
		end
	end

endmodule

/* rtl/core/cpra_ctrl.sv */
// Controller state machine of the page run allocator.
// Sequences the scan, fill and free walk and owns both stream handshakes.
// Depends on cpra_pkg; drives cpra_datapath through command and status structs.
module cpra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 in_cmd,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  cpra_pkg::cpra_stat_t stat,
	output cpra_pkg::cpra_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_FRD  = 3'd3;
	localparam logic [2:0] ST_FCHK = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       mvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = (in_cmd == cpra_pkg::CMD_FREE) ? ST_FRD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (stat.bad_count) begin
					state_d = ST_DONE;
				end else if (stat.scan_hit) begin
					cmd.scan = 1'b1;
					state_d = ST_FILL;
				end else if (stat.scan_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					state_d = ST_DONE;
				end
			end
			ST_FRD: begin
				state_d = ST_FCHK;
			end
			ST_FCHK: begin
				if (stat.walk_cont) begin
					cmd.clear = 1'b1;
					state_d = ST_FRD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!mvalid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/cpra_checker.sv */
// Port-level checker for the page run allocator, bound to its top level.
// Watches the stream handshakes and the result encoding over time.
// Depends only on the ports of contiguous_page_run_allocator_unit.
module cpra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result beat changed while stalled.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[28:0] == 29'd0)
		else $error("Failed result carries a nonzero page or count.");

	a_alloc_no_freed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19:0] != 20'd0 |-> m_tdata[28:20] == 9'd0)
		else $error("Allocate result reports freed pages.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted again before the previous item finished.");

endmodule

bind contiguous_page_run_allocator_unit cpra_checker u_cpra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/contiguous_page_run_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for contiguous_page_run_allocator_unit: directed and random
// allocate/free beats checked against a page map predictor. Depends on cpra_pkg and the RTL.
module contiguous_page_run_allocator_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 2_500_000;
	localparam logic [1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [1:0] REG_UNUSED_HI = 2'd3;

	typedef struct packed {
		logic        ok;
		logic [19:0] page_number;
		logic [8:0]  pages_freed;
	} run_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;

	logic [8:0]  page_map [0:255];
	logic [8:0]  usable_q;
	logic [19:0] base_q;

	run_result_t pending_results [$];
	logic [19:0] live_starts [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 10;
	int unsigned rx_idle_pct = 87;
	int unsigned rx_hold_left = 0;

	contiguous_page_run_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int unsigned map_pages();
		return (usable_q > cpra_pkg::MAX_PAGES) ? int'(cpra_pkg::MAX_PAGES) : int'(usable_q);
	endfunction

	function automatic run_result_t alloc_run(input logic [8:0] count);
		run_result_t r;
		int unsigned lim, streak, first;
		r = '0;
		lim = map_pages();
		streak = 0;
		if (count == 0 || count > lim)
			return r;
		for (int unsigned i = 0; i < lim; i++) begin
			streak = (page_map[i] == 9'd0) ? streak + 1 : 0;
			if (streak == count) begin
				first = i + 1 - count;
				for (int unsigned j = 0; j < count; j++)
					page_map[first + j] = 9'(j + 1);
				r.ok = 1'b1;
				r.page_number = 20'(base_q + first);
				return r;
			end
		end
		return r;
	endfunction

	function automatic run_result_t free_run(input logic [19:0] page);
		run_result_t r;
		logic [19:0] offset;
		int unsigned lim, pos, want, cleared;
		r = '0;
		lim = map_pages();
		offset = page - base_q;
		if (offset >= lim)
			return r;
		pos = 32'(offset);
		if (page_map[pos] == 9'd0)
			return r;
		want = 32'(page_map[pos]);
		cleared = 0;
		while (pos < lim && page_map[pos] == want) begin
			page_map[pos] = '0;
			pos++;
			want++;
			cleared++;
		end
		r.ok = 1'b1;
		r.pages_freed = (cleared > 511) ? 9'h1FF : 9'(cleared);
		return r;
	endfunction

	task automatic send_item(input logic cmd, input logic [8:0] count, input logic [19:0] page);
		int unsigned gap;
		run_result_t want;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, page, count};
		do @(posedge clk); while (s_tready !== 1'b1);
		if (cmd == cpra_pkg::CMD_ALLOC)
			want = alloc_run(count);
		else
			want = free_run(page);
		pending_results.push_back(want);
		if (cmd == cpra_pkg::CMD_ALLOC && want.ok) begin
			live_starts.push_back(want.page_number);
			if (live_starts.size() > 64)
				void'(live_starts.pop_front());
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		if (index == cpra_pkg::REG_USABLE_PAGES)
			usable_q = value[8:0];
		else if (index == cpra_pkg::REG_BASE_PAGE)
			base_q = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		int unsigned pick, size, idx;
		logic [8:0] count;
		logic [19:0] page;
		size = map_pages();
		pick = $urandom_range(99);
		if (pick < 55) begin
			pick = $urandom_range(99);
			if (pick < 70)
				count = 9'($urandom_range(8, 1));
			else if (pick < 90)
				count = 9'($urandom_range(40, 9));
			else if (pick < 94)
				count = 9'd0;
			else if (pick < 97)
				count = 9'($urandom_range(511, 257));
			else
				count = 9'($urandom_range(256, 100));
			send_item(cpra_pkg::CMD_ALLOC, count, 20'($urandom_range(20'hFFFFF)));
		end else begin
			pick = $urandom_range(99);
			if (pick < 65 && live_starts.size() != 0) begin
				idx = $urandom_range(live_starts.size() - 1);
				page = live_starts[idx];
				live_starts.delete(idx);
				if ($urandom_range(99) < 15)
					page = 20'(page + $urandom_range(3, 1));
			end else if (pick < 85) begin
				page = 20'(base_q + $urandom_range(size));
			end else begin
				page = 20'($urandom_range(20'hFFFFF));
			end
			send_item(cpra_pkg::CMD_FREE, 9'($urandom_range(511)), page);
		end
	endtask

	task automatic test_single_runs();
		send_item(cpra_pkg::CMD_ALLOC, 9'd0, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd257, 20'hFFFFF);
		send_item(cpra_pkg::CMD_ALLOC, 9'd1, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd3, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd2);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd1);
		send_item(cpra_pkg::CMD_FREE, 9'h1FF, 20'd1);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd256);
	endtask

	task automatic test_full_map();
		send_item(cpra_pkg::CMD_ALLOC, 9'd256, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd1, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd256, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd255);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd0);
	endtask

	task automatic test_base_wrap();
		drain();
		write_reg(cpra_pkg::REG_BASE_PAGE, 20'hFFFFF);
		send_item(cpra_pkg::CMD_ALLOC, 9'd2, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd3, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd1);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'hFFFFF);
		drain();
		write_reg(cpra_pkg::REG_USABLE_PAGES, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd1, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'hFFFFF);
	endtask

	task automatic test_map_resize();
		drain();
		write_reg(cpra_pkg::REG_USABLE_PAGES, 20'd256);
		write_reg(cpra_pkg::REG_BASE_PAGE, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd200, 20'd0);
		drain();
		write_reg(cpra_pkg::REG_USABLE_PAGES, 20'd100);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd150);
		send_item(cpra_pkg::CMD_ALLOC, 9'd1, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd50);
		drain();
		write_reg(cpra_pkg::REG_USABLE_PAGES, 20'd256);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd100);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd0);
	endtask

	task automatic test_unknown_register();
		drain();
		write_reg(REG_UNUSED_LO, 20'hFFFFF);
		write_reg(REG_UNUSED_HI, 20'd0);
		send_item(cpra_pkg::CMD_ALLOC, 9'd1, 20'd0);
		send_item(cpra_pkg::CMD_FREE, 9'd0, 20'd0);
	endtask

	task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
			input int unsigned beats, input logic [8:0] usable, input logic [19:0] base);
		drain();
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_reg(cpra_pkg::REG_USABLE_PAGES, {11'd0, usable});
		write_reg(cpra_pkg::REG_BASE_PAGE, base);
		repeat (beats) send_random();
	endtask

	task automatic test_output_backpressure();
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 3000;
		repeat (8) send_random();
	endtask

	initial begin : result_monitor
		run_result_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: ok=%0b page_number=%h pages_freed=%0d",
							m_tuser, m_tdata[19:0], m_tdata[28:20]);
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.ok || m_tdata[19:0] !== want.page_number ||
							m_tdata[28:20] !== want.pages_freed) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result mismatch: want ok=%0b page_number=%h ",
								"pages_freed=%0d, got ok=%0b page_number=%h pages_freed=%0d"},
								want.ok, want.page_number, want.pages_freed,
								m_tuser, m_tdata[19:0], m_tdata[28:20]);
					end
				end
			end
			if (rx_hold_left != 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= cpra_pkg::CMD_ALLOC;
		cfg_we <= 1'b0;
		cfg_index <= cpra_pkg::REG_USABLE_PAGES;
		cfg_data <= '0;
		for (int i = 0; i < 256; i++)
			page_map[i] = '0;
		usable_q = cpra_pkg::MAX_PAGES;
		base_q = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_runs();
		test_full_map();
		test_base_wrap();
		test_map_resize();
		test_unknown_register();
		test_random_traffic(10, 87, 110, 9'd256, 20'($urandom_range(20'hFFFFF)));
		test_random_traffic(10, 87, 110, 9'd37, 20'hFFFF0);
		test_random_traffic(87, 10, 110, 9'd256, 20'd0);
		test_random_traffic(87, 10, 110, 9'd200, 20'($urandom_range(20'hFFFFF)));
		test_random_traffic(0, 0, 100, 9'd256, 20'hFFFFF);
		test_output_backpressure();
		test_random_traffic(0, 0, 100, 9'd256, 20'd0);

		drain();
		repeat (600) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
